@@ rtl/assert_macros.svh @@
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/uabd_pkg.sv @@
package uabd_pkg;

    localparam int STAMP_W = 16;
    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 24;
    localparam int DEN_W   = 16;
    localparam int FIN_W   = 25;

    localparam logic [STAMP_W-1:0] DIV_MAX = 16'hFFFF;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_ANALYZE = 1'b1;

    localparam logic [1:0] ST_FEW  = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] REG_RATIO    = 2'd0;
    localparam logic [1:0] REG_SLOWER   = 2'd1;
    localparam logic [1:0] REG_PRESCALE = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [STAMP_W-1:0] edge_stamp;
    } uabd_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [BYTE_W-1:0]  data_byte;
        logic [STAMP_W-1:0] baud_divisor;
    } uabd_result_t;

    typedef struct packed {
        logic store;
        logic res_few;
        logic rd_start;
        logic rd_next;
        logic take_first;
        logic take_bt;
        logic res_zero;
        logic div_iv;
        logic apply;
        logic fill;
        logic div_bt;
        logic mul2;
        logic res_ok;
    } uabd_cmd_t;

    typedef struct packed {
        logic count_lt2;
        logic bt_zero;
        logic more;
        logic div_done;
    } uabd_stat_t;

endpackage

@@ rtl/uart_auto_baud_detector.sv @@
// uart auto-baud detector
// items come in on start/item and are taken when start is high and busy is low.
// an edge item (opcode edge) stores its timer stamp, up to MAX_EDGES of them,
// and gives no result; busy stays low while it is taken.
// an analyze item decodes the first character from the stored stamps and gives
// one result on result, marked by done for exactly one cycle; the receiver
// cannot hold it off, and a new item may be taken while done is high.
// with fewer than two stamps the result follows in the next cycle; otherwise busy
// stays high while the stamps are loaded and checked and, for a nonzero bit time,
// while each decoded interval (at most CHAR_BITS and MAX_EDGES - 2 of them) runs
// through the shared 24-step serial divider that does every interval division and
// the divisor scaling; the result comes in the same cycle that busy falls.
// configuration goes through cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high; writes must be made only while the block is idle, which it does not enforce.
// reset clears the edge count and the capture lock and loads clock_ratio 1,
// timer_is_slower 0 and timer_prescale 4; the stamp store is not cleared.
// after a successful detection, edge items are ignored until reset.
module uart_auto_baud_detector
    import uabd_pkg::*;
#(
    parameter int MAX_EDGES = 10,
    parameter int CHAR_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  uabd_item_t   item,
    output logic         done,
    output uabd_result_t result,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    uabd_cmd_t  cmd;
    uabd_stat_t stat;
    logic       start_ok;

    assign cfg_ready = 1'b1;
    assign start_ok  = start && !busy;

    uabd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .opcode (item.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    uabd_dp #(
        .MAX_EDGES (MAX_EDGES),
        .CHAR_BITS (CHAR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .edge_stamp (item.edge_stamp),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .done       (done),
        .result     (result)
    );

endmodule

@@ rtl/uabd_div.sv @@
`include "assert_macros.svh"

module uabd_div
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] denom_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W-1:0] diff;
    logic             ge;
    logic [NUM_W-1:0] quot_next;
    logic [DEN_W-1:0] rem_next;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[NUM_W-1]};
        ge        = shifted >= {1'b0, denom_reg};
        diff      = shifted[DEN_W-1:0] - denom_reg;
        rem_next  = ge ? diff : shifted[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg  <= numer;
            rem_reg   <= '0;
            denom_reg <= denom;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    `ASSERT_CLK(a_div_denom_nonzero, busy_reg |-> denom_reg != '0, "divide by zero")
    `ASSERT_NEVER(a_div_done_idle, done_reg && busy_reg, "done while still iterating")
    `ASSERT_CLK(a_div_done_after_busy, done_reg |-> $past(busy_reg), "done without a run")

endmodule

@@ rtl/uabd_ctrl.sv @@
module uabd_ctrl
    import uabd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    input  uabd_stat_t stat,
    output uabd_cmd_t  cmd,
    output logic       busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LD0  = 4'd1;
    localparam logic [3:0] S_LD1  = 4'd2;
    localparam logic [3:0] S_CHKT = 4'd3;
    localparam logic [3:0] S_LDK  = 4'd4;
    localparam logic [3:0] S_WIV  = 4'd5;
    localparam logic [3:0] S_FILL = 4'd6;
    localparam logic [3:0] S_DIVB = 4'd7;
    localparam logic [3:0] S_WDB  = 4'd8;
    localparam logic [3:0] S_MUL2 = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_EDGE)
                    begin
                        cmd.store = 1'b1;
                    end
                    else if (stat.count_lt2)
                    begin
                        cmd.res_few = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_LD0;
                    end
                end
            end
            S_LD0:
            begin
                cmd.take_first = 1'b1;
                cmd.rd_next    = 1'b1;
                state_next     = S_LD1;
            end
            S_LD1:
            begin
                cmd.take_bt = 1'b1;
                state_next  = S_CHKT;
            end
            S_CHKT:
            begin
                if (stat.bt_zero)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.more)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_LDK;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_LDK:
            begin
                cmd.div_iv = 1'b1;
                state_next = S_WIV;
            end
            S_WIV:
            begin
                if (stat.div_done)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_CHKT;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                cmd.div_bt = 1'b1;
                state_next = S_WDB;
            end
            S_WDB:
            begin
                if (stat.div_done)
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.res_ok = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

@@ rtl/uabd_dp.sv @@
`include "assert_macros.svh"

module uabd_dp
    import uabd_pkg::*;
#(
    parameter int MAX_EDGES = 10,
    parameter int CHAR_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  uabd_cmd_t          cmd,
    input  logic [STAMP_W-1:0] edge_stamp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output uabd_stat_t         stat,
    output logic               done,
    output uabd_result_t       result
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int FW = $clog2(CHAR_BITS + 1);

    // edge stamp store
    logic [STAMP_W-1:0] mem [MAX_EDGES];
    logic [STAMP_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        idx_reg;
    logic                 lock_reg;
    logic [7:0]           ratio_reg;
    logic                 slower_reg;
    logic [8:0]           pre_reg;
    logic [STAMP_W-1:0]   prev_reg;
    logic [STAMP_W-1:0]   bt_reg;
    logic                 level_reg;
    logic [FW-1:0]        filled_reg;
    logic [CHAR_BITS-1:0] data_reg;
    logic [NUM_W-1:0]     prod1_reg;
    logic [FIN_W-1:0]     prod2_reg;
    logic                 done_reg;
    uabd_result_t         result_reg;

    logic [7:0]           ratio_eff;
    logic [8:0]           pre_eff;
    logic [STAMP_W-1:0]   interval;
    logic                 div_start;
    logic [NUM_W-1:0]     div_numer;
    logic [DEN_W-1:0]     div_denom;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;
    logic [DEN_W-1:0]     div_rem;

    logic                 round_up;
    logic [16:0]          q_round;
    logic [16:0]          nbits;
    logic [17:0]          span_sum;
    logic [FW-1:0]        end_pos;
    logic [CHAR_BITS-1:0] run_mask;
    logic [CHAR_BITS-1:0] data_next;
    logic [BYTE_W-1:0]    byte_w;
    logic [STAMP_W-1:0]   div_sat;

    assign ratio_eff = (ratio_reg == '0) ? 8'd1 : ratio_reg;
    assign pre_eff   = (pre_reg == '0) ? 9'd1 : pre_reg;
    assign interval  = rd_data_reg - prev_reg;

    assign mem_we  = cmd.store && !lock_reg && (count_reg < CW'(MAX_EDGES));
    assign rd_addr = cmd.rd_start ? '0 : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= edge_stamp;
        end
        if (cmd.rd_start || cmd.rd_next)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // bit count of one interval, rounded, at least one, and the data byte update
    always_comb
    begin
        round_up = div_rem > {1'b0, bt_reg[STAMP_W-1:1]};
        q_round  = {1'b0, div_quot[STAMP_W-1:0]} + 17'(round_up);
        nbits    = (q_round == '0) ? 17'd1 : q_round;
        span_sum = 18'(filled_reg) + 18'(nbits);
        if (cmd.fill || span_sum > 18'(CHAR_BITS))
        begin
            end_pos = FW'(CHAR_BITS);
        end
        else
        begin
            end_pos = span_sum[FW-1:0];
        end
        for (int i = 0; i < CHAR_BITS; i++)
        begin
            run_mask[i] = (FW'(i) >= filled_reg) && (FW'(i) < end_pos);
        end
        data_next = level_reg ? (data_reg | run_mask) : data_reg;
    end

    // divider sharing: interval / bit time, then the divisor scaling
    always_comb
    begin
        div_start = cmd.div_iv || cmd.div_bt;
        if (cmd.div_iv)
        begin
            div_numer = NUM_W'(interval);
            div_denom = bt_reg;
        end
        else if (slower_reg)
        begin
            div_numer = prod1_reg;
            div_denom = DEN_W'(pre_eff);
        end
        else
        begin
            div_numer = NUM_W'(bt_reg);
            div_denom = DEN_W'(ratio_eff);
        end
    end

    uabd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign byte_w  = BYTE_W'(data_reg);
    assign div_sat = (prod2_reg > FIN_W'(DIV_MAX)) ? DIV_MAX : prod2_reg[STAMP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            lock_reg   <= 1'b0;
            ratio_reg  <= 8'd1;
            slower_reg <= 1'b0;
            pre_reg    <= 9'd4;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_few || cmd.res_zero || cmd.res_ok;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATIO:    ratio_reg  <= cfg_data[7:0];
                    REG_SLOWER:   slower_reg <= cfg_data[0];
                    REG_PRESCALE: pre_reg    <= cfg_data;
                    default:      ;
                endcase
            end
            if (mem_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.rd_start)
            begin
                idx_reg <= CW'(1);
            end
            else if (cmd.rd_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.res_zero)
            begin
                count_reg <= '0;
            end
            if (cmd.res_ok)
            begin
                count_reg <= '0;
                lock_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_first)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.take_bt)
        begin
            bt_reg     <= interval;
            prev_reg   <= rd_data_reg;
            level_reg  <= 1'b1;
            filled_reg <= '0;
            data_reg   <= '0;
        end
        if (cmd.div_iv)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.apply)
        begin
            data_reg   <= data_next;
            filled_reg <= end_pos;
            level_reg  <= !level_reg;
        end
        if (cmd.fill)
        begin
            data_reg   <= data_next;
            filled_reg <= end_pos;
            prod1_reg  <= NUM_W'(bt_reg) * NUM_W'(ratio_eff);
        end
        if (cmd.mul2)
        begin
            if (slower_reg)
            begin
                prod2_reg <= FIN_W'(div_quot);
            end
            else
            begin
                prod2_reg <= FIN_W'(div_quot[STAMP_W-1:0]) * FIN_W'(pre_eff);
            end
        end
        if (cmd.res_few)
        begin
            result_reg <= '{status: ST_FEW, data_byte: '0, baud_divisor: '0};
        end
        if (cmd.res_zero)
        begin
            result_reg <= '{status: ST_ZERO, data_byte: '0, baud_divisor: '0};
        end
        if (cmd.res_ok)
        begin
            result_reg <= '{status: ST_OK, data_byte: byte_w, baud_divisor: div_sat};
        end
    end

    assign stat.count_lt2 = count_reg < CW'(2);
    assign stat.bt_zero   = bt_reg == '0;
    assign stat.more      = (idx_reg < count_reg) && (filled_reg < FW'(CHAR_BITS));
    assign stat.div_done  = div_done;

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_lock_sticky, lock_reg |=> lock_reg, "capture lock dropped")
    `ASSERT_NEVER(a_count_bound, count_reg > CW'(MAX_EDGES), "edge count overflow")
    `ASSERT_CLK(a_ok_clears, cmd.res_ok |=> lock_reg && count_reg == '0, "detect did not lock")

endmodule
